// File: rtl/handheld_bus_decoder_mbc1_assert.svh
// Assertion macros used by the checker file of the bus decoder.
`ifndef HANDHELD_BUS_DECODER_MBC1_ASSERT_SVH
`define HANDHELD_BUS_DECODER_MBC1_ASSERT_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define HBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled during reset.
`define HBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hbd_pkg.sv
// Types and constants of the bus decoder with its bank controller.
`timescale 1ns / 1ps

package hbd_pkg;

    // One CPU bus access.
    typedef struct packed {
        logic        mode;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } hbd_in_t;

    // One decoded access.
    typedef struct packed {
        logic [3:0]  region;
        logic [18:0] offset;
        logic        store_enable;
        logic        dma_start;
        logic [7:0]  dma_source_page;
        logic        bank_error;
    } hbd_out_t;

    // Region codes.
    localparam logic [3:0] RGN_NONE   = 4'd0;
    localparam logic [3:0] RGN_ROM0   = 4'd1;
    localparam logic [3:0] RGN_ROMX   = 4'd2;
    localparam logic [3:0] RGN_VRAM   = 4'd3;
    localparam logic [3:0] RGN_EXTRAM = 4'd4;
    localparam logic [3:0] RGN_WRAM0  = 4'd5;
    localparam logic [3:0] RGN_WRAM1  = 4'd6;
    localparam logic [3:0] RGN_OAM    = 4'd7;
    localparam logic [3:0] RGN_IO     = 4'd8;
    localparam logic [3:0] RGN_HRAM   = 4'd9;
    localparam logic [3:0] RGN_IE     = 4'd10;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CONTROLLER_KIND = 2'd0;
    localparam logic [1:0] CFG_ROM_BANK_COUNT  = 2'd1;
    localparam logic [1:0] CFG_EXT_RAM_MODE    = 2'd2;

    // Controller and external RAM codes.
    localparam logic       KIND_MBC1      = 1'b1;
    localparam logic [1:0] EXTRAM_NONE    = 2'd0;
    localparam logic [1:0] EXTRAM_2K      = 2'd1;

    // Access kind.
    localparam logic MODE_WRITE = 1'b1;

    // Address map boundaries.
    localparam logic [15:0] ADDR_IE      = 16'hFFFF;
    localparam logic [15:0] ADDR_HRAM    = 16'hFF80;
    localparam logic [15:0] ADDR_IO      = 16'hFF00;
    localparam logic [15:0] ADDR_DMA     = 16'hFF46;
    localparam logic [15:0] ADDR_UNUSED  = 16'hFEA0;
    localparam logic [15:0] ADDR_OAM     = 16'hFE00;
    localparam logic [15:0] ADDR_ECHO1   = 16'hF000;
    localparam logic [15:0] ADDR_ECHO0   = 16'hE000;
    localparam logic [15:0] ADDR_WRAM1   = 16'hD000;
    localparam logic [15:0] ADDR_WRAM0   = 16'hC000;
    localparam logic [15:0] ADDR_EXT_2K  = 16'hA800;
    localparam logic [15:0] ADDR_EXTRAM  = 16'hA000;
    localparam logic [15:0] ADDR_VRAM    = 16'h8000;
    localparam logic [15:0] ADDR_ROMX    = 16'h4000;
    localparam logic [15:0] ADDR_BANKSEL = 16'h2000;

    // Bank register value after reset.
    localparam logic [7:0] ROM_BANK_RESET = 8'd1;

endpackage

// File: rtl/handheld_bus_decoder_mbc1.sv
// Top level of the CPU bus decoder with its MBC1 ROM bank register.
//
//  Channel  | Ports                          | Carries
//  ---------+--------------------------------+------------------------------
//  input    | s_valid, s_ready, s_payload    | one bus access (hbd_in_t)
//  result   | m_valid, m_ready, m_payload    | one decoded access (hbd_out_t)
//  config   | psel, penable, pwrite, paddr,  | controller kind, bank count,
//           | pwdata, prdata, pready         | external RAM mode
//
// Each transaction passes through the input register and then the result
// register. A new transaction is taken every cycle unless the result side stalls.
// The bank register is updated as a transaction moves into the result register,
// so the following transaction already decodes with the new bank.
// Reset is synchronous; a stall on the result side holds the result stage and a full input stage in place.
`timescale 1ns / 1ps

module handheld_bus_decoder_mbc1 (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hbd_pkg::hbd_in_t   s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output hbd_pkg::hbd_out_t  m_payload,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import hbd_pkg::*;

    logic       controller_kind_reg;
    logic [5:0] rom_bank_count_reg;
    logic [1:0] ext_ram_mode_reg;
    logic [7:0] rom_bank_reg;
    logic [7:0] rom_bank_next;

    logic       in_valid_reg;
    hbd_in_t    in_reg;
    logic       out_valid_reg;
    hbd_out_t   out_reg;
    hbd_out_t   out_next;

    logic       advance;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] bank_value;

    // Pipeline flow control: the input stage moves on when the result stage is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_payload = out_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_comb begin
        unique case (cfg_index)
            CFG_CONTROLLER_KIND: prdata = {31'd0, controller_kind_reg};
            CFG_ROM_BANK_COUNT:  prdata = {26'd0, rom_bank_count_reg};
            CFG_EXT_RAM_MODE:    prdata = {30'd0, ext_ram_mode_reg};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            controller_kind_reg <= 1'b0;
            rom_bank_count_reg  <= 6'd0;
            ext_ram_mode_reg    <= EXTRAM_NONE;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_CONTROLLER_KIND: controller_kind_reg <= pwdata[0];
                CFG_ROM_BANK_COUNT:  rom_bank_count_reg  <= pwdata[5:0];
                CFG_EXT_RAM_MODE:    ext_ram_mode_reg    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Decode of the registered access and the bank register update.
    assign bank_value = (in_reg.write_byte == 8'd0) ? 8'd1 : in_reg.write_byte;

    always_comb begin
        logic        wr;
        logic [15:0] a;
        wr = (in_reg.mode == MODE_WRITE);
        a  = in_reg.bus_address;
        out_next      = '0;
        rom_bank_next = rom_bank_reg;
        priority if (a == ADDR_IE) begin
            out_next.region       = RGN_IE;
            out_next.store_enable = wr;
        end else if (a >= ADDR_HRAM) begin
            out_next.region       = RGN_HRAM;
            out_next.offset       = {3'd0, a - ADDR_HRAM};
            out_next.store_enable = wr;
        end else if (a >= ADDR_IO) begin
            out_next.region = RGN_IO;
            out_next.offset = {3'd0, a - ADDR_IO};
            if (wr && a == ADDR_DMA) begin
                out_next.dma_start       = 1'b1;
                out_next.dma_source_page = in_reg.write_byte;
            end else begin
                out_next.store_enable = wr;
            end
        end else if (a >= ADDR_UNUSED) begin
            out_next.region = RGN_NONE;
        end else if (a >= ADDR_OAM) begin
            out_next.region       = RGN_OAM;
            out_next.offset       = {3'd0, a - ADDR_OAM};
            out_next.store_enable = wr;
        end else if (a >= ADDR_ECHO1) begin
            // Upper echo mirrors wram1.
            out_next.region       = RGN_WRAM1;
            out_next.offset       = {3'd0, a - ADDR_ECHO1};
            out_next.store_enable = wr;
        end else if (a >= ADDR_ECHO0) begin
            // Lower echo mirrors wram0.
            out_next.region       = RGN_WRAM0;
            out_next.offset       = {3'd0, a - ADDR_ECHO0};
            out_next.store_enable = wr;
        end else if (a >= ADDR_WRAM1) begin
            out_next.region       = RGN_WRAM1;
            out_next.offset       = {3'd0, a - ADDR_WRAM1};
            out_next.store_enable = wr;
        end else if (a >= ADDR_WRAM0) begin
            out_next.region       = RGN_WRAM0;
            out_next.offset       = {3'd0, a - ADDR_WRAM0};
            out_next.store_enable = wr;
        end else if (a >= ADDR_EXTRAM) begin
            // External RAM is blocked when absent or beyond the 2 KB window.
            if (ext_ram_mode_reg == EXTRAM_NONE ||
                (ext_ram_mode_reg == EXTRAM_2K && a >= ADDR_EXT_2K)) begin
                out_next.region = RGN_NONE;
            end else begin
                out_next.region       = RGN_EXTRAM;
                out_next.offset       = {3'd0, a - ADDR_EXTRAM};
                out_next.store_enable = wr;
            end
        end else if (a >= ADDR_VRAM) begin
            out_next.region       = RGN_VRAM;
            out_next.offset       = {3'd0, a - ADDR_VRAM};
            out_next.store_enable = wr;
        end else if (a >= ADDR_ROMX) begin
            // Bank times 16 KB plus the window offset, kept to 19 bits.
            out_next.region = RGN_ROMX;
            out_next.offset = {rom_bank_reg[4:0], a[13:0]};
        end else begin
            out_next.region = RGN_ROM0;
            out_next.offset = {3'd0, a};
            if (wr && controller_kind_reg == KIND_MBC1 && a >= ADDR_BANKSEL) begin
                if (bank_value < {2'd0, rom_bank_count_reg}) begin
                    rom_bank_next = bank_value;
                end else begin
                    out_next.bank_error = 1'b1;
                end
            end
        end
    end

    // Control state: stage valid flags and the bank register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rom_bank_reg  <= ROM_BANK_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                rom_bank_reg  <= rom_bank_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/hbd_checker.sv
// Port-level checker of the bus decoder and its bind to the top level.
`timescale 1ns / 1ps
`include "handheld_bus_decoder_mbc1_assert.svh"

module hbd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input hbd_pkg::hbd_in_t   s_payload,
    input logic               m_valid,
    input logic               m_ready,
    input hbd_pkg::hbd_out_t  m_payload
);
    import hbd_pkg::*;

    // A DMA start is an IO access that stores nothing.
    `HBD_ASSERT_IMP(a_dma_is_io, m_valid && m_payload.dma_start, m_payload.region == RGN_IO && !m_payload.store_enable, "DMA start outside IO or with store")

    // A rejected bank write is a ROM0 access that stores nothing.
    `HBD_ASSERT_IMP(a_bank_err_rom0, m_valid && m_payload.bank_error, m_payload.region == RGN_ROM0 && !m_payload.store_enable && !m_payload.dma_start, "bank error on a non-ROM0 transaction")

    // A blocked or unmapped access carries no offset and stores nothing.
    `HBD_ASSERT_IMP(a_none_quiet, m_valid && m_payload.region == RGN_NONE, m_payload.offset == 19'd0 && !m_payload.store_enable, "unmapped transaction with offset or store")

    // A stalled result holds its payload.
    `HBD_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_payload), "stalled result changed")

    // A waiting input transaction stays valid with the same payload.
    `HBD_ASSERT_NXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_payload), "waiting input changed")

endmodule

bind handheld_bus_decoder_mbc1 hbd_checker u_hbd_checker (.*);

// File: test/handheld_bus_decoder_mbc1_tb.sv
// Self-checking testbench for the CPU bus decoder with its MBC1 ROM bank register.
`timescale 1ns / 1ps

module handheld_bus_decoder_mbc1_tb;
    import hbd_pkg::*;

    // Codes that the package does not name.
    localparam logic       KIND_ROM_ONLY = 1'b0;
    localparam logic [1:0] EXTRAM_8K     = 2'd2;
    localparam logic [1:0] EXTRAM_32K    = 2'd3;
    localparam logic       MODE_READ     = 1'b0;

    // Cycles without any transaction before the run is declared hung.
    localparam int IDLE_LIMIT = 3000;
    localparam int RANDOM_PER_SETTING = 238;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    hbd_in_t     s_payload = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    hbd_out_t    m_payload;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // Decoder state as the testbench expects it.
    logic        cfg_kind       = 1'b0;
    logic [5:0]  cfg_bank_count = '0;
    logic [1:0]  cfg_ram_mode   = EXTRAM_NONE;
    logic [7:0]  model_bank     = ROM_BANK_RESET;

    hbd_out_t    decoded_q[$];
    int unsigned idle_pct      = 0;
    int unsigned stall_pct     = 0;
    int unsigned fail_count    = 0;
    int unsigned sent_count    = 0;
    int unsigned checked_count = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles  = 0;

    handheld_bus_decoder_mbc1 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Decode one access and apply its effect on the bank register.
    function automatic hbd_out_t decode_access(input hbd_in_t acc);
        hbd_out_t   r;
        logic [15:0] a;
        logic [7:0]  sel;
        r = '0;
        a = acc.bus_address;
        if (a == ADDR_IE) begin
            r.region = RGN_IE;
            r.store_enable = acc.mode;
        end else if (a >= ADDR_HRAM) begin
            r.region = RGN_HRAM;
            r.offset = 19'(a - ADDR_HRAM);
            r.store_enable = acc.mode;
        end else if (a >= ADDR_IO) begin
            r.region = RGN_IO;
            r.offset = 19'(a - ADDR_IO);
            if (acc.mode == MODE_WRITE && a == ADDR_DMA) begin
                r.dma_start = 1'b1;
                r.dma_source_page = acc.write_byte;
            end else begin
                r.store_enable = acc.mode;
            end
        end else if (a >= ADDR_UNUSED) begin
            r.region = RGN_NONE;
        end else if (a >= ADDR_OAM) begin
            r.region = RGN_OAM;
            r.offset = 19'(a - ADDR_OAM);
            r.store_enable = acc.mode;
        end else if (a >= ADDR_ECHO1) begin
            // The upper echo half mirrors the switchable work RAM.
            r.region = RGN_WRAM1;
            r.offset = 19'(a - ADDR_ECHO1);
            r.store_enable = acc.mode;
        end else if (a >= ADDR_ECHO0) begin
            r.region = RGN_WRAM0;
            r.offset = 19'(a - ADDR_ECHO0);
            r.store_enable = acc.mode;
        end else if (a >= ADDR_WRAM1) begin
            r.region = RGN_WRAM1;
            r.offset = 19'(a - ADDR_WRAM1);
            r.store_enable = acc.mode;
        end else if (a >= ADDR_WRAM0) begin
            r.region = RGN_WRAM0;
            r.offset = 19'(a - ADDR_WRAM0);
            r.store_enable = acc.mode;
        end else if (a >= ADDR_EXTRAM) begin
            // External RAM is blocked when absent, and above 2 KB in the small mode.
            if (cfg_ram_mode == EXTRAM_NONE || (cfg_ram_mode == EXTRAM_2K && a >= ADDR_EXT_2K)) begin
                r.region = RGN_NONE;
            end else begin
                r.region = RGN_EXTRAM;
                r.offset = 19'(a - ADDR_EXTRAM);
                r.store_enable = acc.mode;
            end
        end else if (a >= ADDR_VRAM) begin
            r.region = RGN_VRAM;
            r.offset = 19'(a - ADDR_VRAM);
            r.store_enable = acc.mode;
        end else if (a >= ADDR_ROMX) begin
            // The bank offset wraps at 19 bits.
            r.region = RGN_ROMX;
            r.offset = 19'(a - ADDR_ROMX) + 19'({model_bank, 14'd0});
        end else begin
            r.region = RGN_ROM0;
            r.offset = 19'(a);
            if (acc.mode == MODE_WRITE && cfg_kind == KIND_MBC1 && a >= ADDR_BANKSEL) begin
                sel = (acc.write_byte == 8'd0) ? 8'd1 : acc.write_byte;
                if (sel < {2'b00, cfg_bank_count}) begin
                    model_bank = sel;
                end else begin
                    r.bank_error = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic hbd_in_t bus_access(input logic mode, input logic [15:0] addr,
                                           input logic [7:0] data);
        hbd_in_t acc;
        acc.mode = mode;
        acc.bus_address = addr;
        acc.write_byte = data;
        return acc;
    endfunction

    // Random access, weighted toward bank selects, banked ROM, external RAM and the top page.
    function automatic hbd_in_t random_access();
        hbd_in_t     acc;
        int unsigned pick;
        pick = $urandom_range(99);
        acc.mode = 1'($urandom_range(1));
        acc.bus_address = 16'($urandom());
        acc.write_byte = 8'($urandom());
        if (pick < 30) begin
            acc.mode = MODE_WRITE;
            acc.bus_address = ADDR_BANKSEL + 16'($urandom_range(16'h1FFF));
            if ($urandom_range(3) != 0) begin
                acc.write_byte = 8'($urandom_range(int'(cfg_bank_count) + 1));
            end
        end else if (pick < 50) begin
            acc.bus_address = ADDR_ROMX + 16'($urandom_range(16'h3FFF));
        end else if (pick < 60) begin
            acc.bus_address = ADDR_EXTRAM + 16'($urandom_range(16'h1FFF));
        end else if (pick < 67) begin
            acc.bus_address = ADDR_OAM + 16'($urandom_range(16'h1FF));
        end else if (pick < 70) begin
            acc.mode = MODE_WRITE;
            acc.bus_address = ADDR_DMA;
        end
        return acc;
    endfunction

    // Present one access, wait for its transaction and record the expected decode.
    task automatic send_access(input hbd_in_t acc);
        @(negedge aclk);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < idle_pct) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= acc;
        do @(posedge aclk); while (!s_ready);
        decoded_q.push_back(decode_access(acc));
        sent_count++;
    endtask

    // Stop sending and wait until every decode has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
    endtask

    // One register write followed by a read back of the same register.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback_want;
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            CFG_CONTROLLER_KIND: cfg_kind = value[0];
            CFG_ROM_BANK_COUNT:  cfg_bank_count = value[5:0];
            CFG_EXT_RAM_MODE:    cfg_ram_mode = value[1:0];
            default: ;
        endcase
        @(negedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            CFG_CONTROLLER_KIND: readback_want = {31'd0, cfg_kind};
            CFG_ROM_BANK_COUNT:  readback_want = {26'd0, cfg_bank_count};
            default:             readback_want = {30'd0, cfg_ram_mode};
        endcase
        if (prdata !== readback_want) begin
            $display("%0t ns: register %0d read back, expected 0x%0h, got 0x%0h",
                     $time, idx, readback_want, prdata);
            fail_count++;
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic kind, input logic [5:0] bank_count,
                             input logic [1:0] ram_mode);
        wait_drained();
        write_register(CFG_CONTROLLER_KIND, {31'd0, kind});
        write_register(CFG_ROM_BANK_COUNT, {26'd0, bank_count});
        write_register(CFG_EXT_RAM_MODE, {30'd0, ram_mode});
        settings_used++;
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Compare each decoded transaction with the oldest expectation.
    always @(posedge aclk) begin : check_results
        hbd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got %p", $time, m_payload);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                compare_field("region", want.region, m_payload.region);
                compare_field("offset", want.offset, m_payload.offset);
                compare_field("store_enable", want.store_enable, m_payload.store_enable);
                compare_field("dma_start", want.dma_start, m_payload.dma_start);
                compare_field("dma_source_page", want.dma_source_page, m_payload.dma_source_page);
                compare_field("bank_error", want.bank_error, m_payload.bank_error);
                checked_count++;
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hang detection: any transaction on any port restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Decode with the reset configuration: ROM only, no external RAM.
    task automatic test_reset_defaults();
        send_access(bus_access(MODE_READ, ADDR_ROMX, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_BANKSEL, 8'h05));
        send_access(bus_access(MODE_READ, 16'h7FFF, 8'hFF));
        send_access(bus_access(MODE_READ, ADDR_EXTRAM, 8'h00));
        send_access(bus_access(MODE_WRITE, 16'hBFFF, 8'hA5));
    endtask

    // Region edges from ROM up to OAM, with 2 KB external RAM.
    task automatic test_address_map();
        configure(KIND_ROM_ONLY, 6'd4, EXTRAM_2K);
        send_access(bus_access(MODE_READ, 16'h0000, 8'h00));
        send_access(bus_access(MODE_WRITE, 16'h1FFF, 8'hFF));
        send_access(bus_access(MODE_READ, 16'h3FFF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_ROMX, 8'h12));
        send_access(bus_access(MODE_READ, 16'h7FFF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_VRAM, 8'h55));
        send_access(bus_access(MODE_READ, 16'h9FFF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_EXTRAM, 8'hAA));
        send_access(bus_access(MODE_READ, 16'hA7FF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_EXT_2K, 8'h01));
        send_access(bus_access(MODE_READ, 16'hBFFF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_WRAM0, 8'h80));
        send_access(bus_access(MODE_READ, 16'hCFFF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_WRAM1, 8'h7F));
        send_access(bus_access(MODE_READ, 16'hDFFF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_ECHO0, 8'h33));
        send_access(bus_access(MODE_READ, 16'hEFFF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_ECHO1, 8'hCC));
        send_access(bus_access(MODE_READ, 16'hFDFF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_OAM, 8'h0F));
        send_access(bus_access(MODE_READ, 16'hFE9F, 8'h00));
    endtask

    // Unusable area, IO with the DMA register, high RAM and interrupt enable.
    task automatic test_io_window();
        send_access(bus_access(MODE_WRITE, ADDR_UNUSED, 8'hFF));
        send_access(bus_access(MODE_READ, 16'hFEFF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_IO, 8'h01));
        send_access(bus_access(MODE_WRITE, ADDR_DMA, 8'hFF));
        send_access(bus_access(MODE_WRITE, ADDR_DMA, 8'h00));
        send_access(bus_access(MODE_READ, ADDR_DMA, 8'hC3));
        send_access(bus_access(MODE_WRITE, 16'hFF7F, 8'h5A));
        send_access(bus_access(MODE_WRITE, ADDR_HRAM, 8'hA5));
        send_access(bus_access(MODE_READ, 16'hFFFE, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_IE, 8'h1F));
        send_access(bus_access(MODE_READ, ADDR_IE, 8'h00));
    endtask

    // Bank selects: zero becomes one, the count limit, oversized counts and ROM only.
    task automatic test_bank_select();
        configure(KIND_MBC1, 6'd32, EXTRAM_NONE);
        send_access(bus_access(MODE_WRITE, ADDR_BANKSEL, 8'h00));
        send_access(bus_access(MODE_READ, ADDR_ROMX, 8'h00));
        send_access(bus_access(MODE_WRITE, 16'h3FFF, 8'd31));
        send_access(bus_access(MODE_READ, 16'h7FFF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_BANKSEL, 8'd32));
        send_access(bus_access(MODE_WRITE, 16'h2ABC, 8'hFF));
        send_access(bus_access(MODE_WRITE, 16'h1FFF, 8'h05));
        send_access(bus_access(MODE_READ, ADDR_ROMX, 8'h00));
        configure(KIND_MBC1, 6'd63, EXTRAM_32K);
        send_access(bus_access(MODE_WRITE, 16'h3000, 8'd62));
        send_access(bus_access(MODE_READ, ADDR_ROMX, 8'h00));
        send_access(bus_access(MODE_READ, 16'h7FFF, 8'h00));
        send_access(bus_access(MODE_WRITE, ADDR_BANKSEL, 8'd63));
        send_access(bus_access(MODE_WRITE, 16'hBFFF, 8'h99));
        configure(KIND_MBC1, 6'd0, EXTRAM_8K);
        send_access(bus_access(MODE_WRITE, ADDR_BANKSEL, 8'h00));
        send_access(bus_access(MODE_WRITE, 16'hBFFF, 8'h66));
        configure(KIND_ROM_ONLY, 6'd8, EXTRAM_8K);
        send_access(bus_access(MODE_WRITE, ADDR_BANKSEL, 8'h03));
        send_access(bus_access(MODE_READ, ADDR_ROMX, 8'h00));
    endtask

    // Random traffic under one idle pattern, over two register settings.
    task automatic test_random_traffic(input int unsigned phase, input int unsigned in_idle,
                                       input int unsigned out_stall);
        wait_drained();
        idle_pct = in_idle;
        stall_pct = out_stall;
        for (int k = 0; k < 2; k++) begin
            case (phase * 2 + k)
                0: configure(KIND_MBC1, 6'd32, EXTRAM_32K);
                1: configure(KIND_ROM_ONLY, 6'd0, EXTRAM_NONE);
                2: configure(KIND_MBC1, 6'd63, EXTRAM_2K);
                3: configure(KIND_MBC1, 6'd2, EXTRAM_8K);
                4: configure(KIND_MBC1, 6'd1, EXTRAM_NONE);
                5: configure(KIND_ROM_ONLY, 6'd16, EXTRAM_32K);
                6: configure(KIND_MBC1, 6'd33, EXTRAM_2K);
                default: configure(KIND_MBC1, 6'd8, EXTRAM_8K);
            endcase
            for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
                send_access(random_access());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_address_map();
        test_io_window();
        test_bank_select();
        test_random_traffic(0, 0, 0);
        test_random_traffic(1, 84, 0);
        test_random_traffic(2, 0, 84);
        test_random_traffic(3, 12, 12);

        wait_drained();
        stall_pct = 0;
        repeat (8) @(posedge aclk);

        $display("Sent %0d bus accesses over %0d register settings and four idle patterns.",
                 sent_count, settings_used);
        $display("Checked %0d decoded results; %0d mismatches found.", checked_count, fail_count);
        if (fail_count == 0 && decoded_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: handheld_bus_decoder_mbc1.f
+incdir+rtl
rtl/hbd_pkg.sv
rtl/handheld_bus_decoder_mbc1.sv
rtl/hbd_checker.sv
test/handheld_bus_decoder_mbc1_tb.sv
